// File: hw/rtl/rcu_pkg.sv
`default_nettype none
package rcu_pkg;

  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int HEX_CHARS_DEF      = 8;
  localparam int DECIMAL_DIGITS_DEF = 10;

  localparam int OP_W   = 3;
  localparam int MUL_W  = 2;
  localparam int DIG_W  = 4;
  localparam int BYTE_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_BIN_TO_VAL = 3'd0,
    OP_OCT_TO_VAL = 3'd1,
    OP_HEX_TO_VAL = 3'd2,
    OP_VAL_TO_BIN = 3'd3,
    OP_VAL_TO_OCT = 3'd4,
    OP_VAL_TO_HEX = 3'd5
  } op_t;

  typedef enum logic [MUL_W-1:0] {
    MUL_2  = 2'd0,
    MUL_8  = 2'd1,
    MUL_10 = 2'd2,
    MUL_16 = 2'd3
  } mul_t;

  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9 = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_F = 8'h46;

  // non-hex characters give zero
  function automatic logic [DIG_W-1:0] hex_char_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_A && c <= CH_F) begin
      t = c - CH_A + 8'd10;
    end
    return t[DIG_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] hex_ascii(input logic [DIG_W-1:0] d);
    logic [BYTE_W-1:0] t;
    if (d <= 4'd9) begin
      t = CH_0 + {4'd0, d};
    end else begin
      t = CH_A + {4'd0, d} - 8'd10;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rcu_in_if.sv
`default_nettype none
interface rcu_in_if #(
  parameter int VALUE_WIDTH = rcu_pkg::VALUE_WIDTH_DEF,
  parameter int HEX_CHARS   = rcu_pkg::HEX_CHARS_DEF
);
  localparam int LEN_W = $clog2(HEX_CHARS + 1);

  logic                                   valid;
  logic                                   ready;
  logic [rcu_pkg::OP_W-1:0]               opcode;
  logic signed [VALUE_WIDTH-1:0]          operand_value;
  logic [rcu_pkg::BYTE_W*HEX_CHARS-1:0]   hex_text_in;
  logic [LEN_W-1:0]                       hex_length_in;

  modport source (output valid, opcode, operand_value, hex_text_in, hex_length_in,
                  input ready);
  modport sink   (input valid, opcode, operand_value, hex_text_in, hex_length_in,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcu_out_if.sv
`default_nettype none
interface rcu_out_if #(
  parameter int VALUE_WIDTH = rcu_pkg::VALUE_WIDTH_DEF,
  parameter int HEX_CHARS   = rcu_pkg::HEX_CHARS_DEF
);
  localparam int LEN_W = $clog2(HEX_CHARS + 1);

  logic                                   valid;
  logic                                   ready;
  logic signed [VALUE_WIDTH-1:0]          result_value;
  logic [rcu_pkg::BYTE_W*HEX_CHARS-1:0]   hex_text_out;
  logic [LEN_W-1:0]                       hex_length_out;
  logic                                   overflow;

  modport source (output valid, result_value, hex_text_out, hex_length_out, overflow,
                  input ready);
  modport sink   (input valid, result_value, hex_text_out, hex_length_out, overflow,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcu_dabble_cell.sv
`default_nettype none
module rcu_dabble_cell #(
  parameter int DIGITS = rcu_pkg::DECIMAL_DIGITS_DEF,
  parameter int SB_W   = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              valid_i,
  input  wire logic                              bit_i,
  input  wire logic [rcu_pkg::DIG_W*DIGITS-1:0]  bcd_i,
  input  wire logic [SB_W-1:0]                   sb_i,
  output logic                                   valid_o,
  output logic [rcu_pkg::DIG_W*DIGITS-1:0]       bcd_o,
  output logic [SB_W-1:0]                        sb_o
);
  import rcu_pkg::*;

  localparam int BCD_W = DIG_W * DIGITS;

  logic [BCD_W-1:0] adj;
  logic [BCD_W-1:0] bcd_nxt;
  logic [BCD_W-1:0] bcd_r;
  logic [SB_W-1:0]  sb_r;
  logic             valid_r;

  // add three to every digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[i*DIG_W +: DIG_W] >= 4'd5) begin
        adj[i*DIG_W +: DIG_W] = bcd_i[i*DIG_W +: DIG_W] + 4'd3;
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_i[i*DIG_W +: DIG_W];
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], bit_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_r <= bcd_nxt;
      sb_r  <= sb_i;
    end
  end

  assign valid_o = valid_r;
  assign bcd_o   = bcd_r;
  assign sb_o    = sb_r;

endmodule
`default_nettype wire

// File: hw/rtl/rcu_horner_cell.sv
`default_nettype none
module rcu_horner_cell #(
  parameter int VALUE_WIDTH = rcu_pkg::VALUE_WIDTH_DEF,
  parameter int SB_W        = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_i,
  input  wire logic [VALUE_WIDTH-1:0]     acc_i,
  input  wire logic                       big_i,
  input  wire logic [rcu_pkg::DIG_W-1:0]  digit_i,
  input  wire rcu_pkg::mul_t              mul_i,
  input  wire logic [SB_W-1:0]            sb_i,
  output logic                            valid_o,
  output logic [VALUE_WIDTH-1:0]          acc_o,
  output logic                            big_o,
  output logic [SB_W-1:0]                 sb_o
);
  import rcu_pkg::*;

  localparam int EXT_W = VALUE_WIDTH + 5;

  logic [EXT_W-1:0]       a;
  logic [EXT_W-1:0]       prod;
  logic [EXT_W-1:0]       sum;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  logic                   big_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic                   big_r;
  logic                   valid_r;
  logic [SB_W-1:0]        sb_r;

  always_comb begin
    a = {{(EXT_W-VALUE_WIDTH){1'b0}}, acc_i};
    case (mul_i)
      MUL_2:   prod = a << 1;
      MUL_8:   prod = a << 3;
      MUL_10:  prod = (a << 3) + (a << 1);
      MUL_16:  prod = a << 4;
      default: prod = a << 1;
    endcase
    sum     = prod + {{(EXT_W-DIG_W){1'b0}}, digit_i};
    // sticky once the running value leaves the signed range
    big_nxt = big_i || (|sum[EXT_W-1:VALUE_WIDTH-1]);
    acc_nxt = sum[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      big_r <= big_nxt;
      sb_r  <= sb_i;
    end
  end

  assign valid_o = valid_r;
  assign acc_o   = acc_r;
  assign big_o   = big_r;
  assign sb_o    = sb_r;

endmodule
`default_nettype wire

// File: hw/rtl/radix_conversion_unit.sv
// radix conversion unit
// in_ch carries one request word: opcode, operand_value, hex_text_in and
// hex_length_in. out_ch returns one result word per request: result_value,
// hex_text_out, hex_length_out and overflow, in request order.
// a request first runs through VALUE_WIDTH-1 double-dabble cells that build the
// decimal digits of the operand, then through one multiply-accumulate cell per
// digit position (the larger of VALUE_WIDTH-1, DECIMAL_DIGITS and HEX_CHARS),
// then into the output register.
// throughput: one word per cycle while the skid register is empty.
// a two-entry output stage (output register plus skid register) lets the chain
// keep accepting while a result waits; in_ch.ready drops only once the skid
// register holds a word, and the whole chain then holds still.
// reset (rst_n low, synchronous) empties the chain and the output stage.
`default_nettype none
module radix_conversion_unit #(
  parameter int VALUE_WIDTH    = rcu_pkg::VALUE_WIDTH_DEF,
  parameter int HEX_CHARS      = rcu_pkg::HEX_CHARS_DEF,
  parameter int DECIMAL_DIGITS = rcu_pkg::DECIMAL_DIGITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rcu_in_if.sink    in_ch,
  rcu_out_if.source out_ch
);
  import rcu_pkg::*;

  localparam int MAG_W  = VALUE_WIDTH - 1;
  localparam int LEN_W  = $clog2(HEX_CHARS + 1);
  localparam int TEXT_W = BYTE_W * HEX_CHARS;
  localparam int BCD_W  = DIG_W * DECIMAL_DIGITS;
  localparam int NOCT   = (MAG_W + 2) / 3;
  localparam int OCT_W  = 3 * NOCT;
  localparam int NDIG_A = (DECIMAL_DIGITS > MAG_W) ? DECIMAL_DIGITS : MAG_W;
  localparam int NDIG   = (HEX_CHARS > NDIG_A) ? HEX_CHARS : NDIG_A;
  localparam int DIGS_W = DIG_W * NDIG;
  localparam int NX_W   = MAG_W + DIG_W * HEX_CHARS;
  localparam int SB1_W  = OP_W + MAG_W + TEXT_W + LEN_W;
  localparam int SB2_W  = TEXT_W + LEN_W + 1 + MUL_W + DIGS_W;
  localparam int RES_W  = VALUE_WIDTH + TEXT_W + LEN_W + 1;
  localparam int MAG_LO = LEN_W + TEXT_W;

  logic en;

  // dabble chain
  logic [MAG_W:0]   d_valid;
  logic [BCD_W-1:0] d_bcd [0:MAG_W];
  logic [SB1_W-1:0] d_sb  [0:MAG_W];
  logic [MAG_W-1:0] mag_in;

  assign mag_in     = in_ch.operand_value[VALUE_WIDTH-1] ? '0
                                                         : in_ch.operand_value[MAG_W-1:0];
  assign d_valid[0] = in_ch.valid;
  assign d_bcd[0]   = '0;
  assign d_sb[0]    = {in_ch.opcode, mag_in, in_ch.hex_text_in, in_ch.hex_length_in};

  for (genvar j = 0; j < MAG_W; j++) begin : g_dabble
    rcu_dabble_cell #(
      .DIGITS (DECIMAL_DIGITS),
      .SB_W   (SB1_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (d_valid[j]),
      .bit_i   (d_sb[j][MAG_LO + MAG_W - 1 - j]),
      .bcd_i   (d_bcd[j]),
      .sb_i    (d_sb[j]),
      .valid_o (d_valid[j+1]),
      .bcd_o   (d_bcd[j+1]),
      .sb_o    (d_sb[j+1])
    );
  end

  // digit selection
  op_t               p_op;
  logic [MAG_W-1:0]  p_mag;
  logic [TEXT_W-1:0] p_text;
  logic [LEN_W-1:0]  p_len;
  logic [LEN_W-1:0]  len_eff;
  logic [OCT_W-1:0]  magx;
  logic [NX_W-1:0]   nx;
  logic [TEXT_W-1:0] emit_text;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_ovf;
  logic [DIGS_W-1:0] digs;
  mul_t              mul;
  logic [TEXT_W-1:0] sel_text;
  logic [LEN_W-1:0]  sel_len;
  logic              sel_ovf;

  assign p_op    = op_t'(d_sb[MAG_W][SB1_W-1 -: OP_W]);
  assign p_mag   = d_sb[MAG_W][MAG_LO +: MAG_W];
  assign p_text  = d_sb[MAG_W][LEN_W +: TEXT_W];
  assign p_len   = d_sb[MAG_W][LEN_W-1:0];
  assign len_eff = (p_len > LEN_W'(HEX_CHARS)) ? LEN_W'(HEX_CHARS) : p_len;
  assign magx    = OCT_W'(p_mag);
  assign nx      = NX_W'(p_mag);

  always_comb begin
    emit_len = '0;
    for (int i = 0; i < HEX_CHARS; i++) begin
      if (nx[i*DIG_W +: DIG_W] != '0) begin
        emit_len = LEN_W'(i + 1);
      end
    end
    for (int i = 0; i < HEX_CHARS; i++) begin
      emit_text[i*BYTE_W +: BYTE_W] = (LEN_W'(i) < emit_len) ?
                                      hex_ascii(nx[i*DIG_W +: DIG_W]) : '0;
    end
    emit_ovf = |nx[NX_W-1:DIG_W*HEX_CHARS];
  end

  always_comb begin
    digs     = '0;
    mul      = MUL_2;
    sel_text = '0;
    sel_len  = '0;
    sel_ovf  = 1'b0;
    unique case (p_op)
      OP_BIN_TO_VAL: begin
        mul              = MUL_2;
        digs[BCD_W-1:0]  = d_bcd[MAG_W];
      end
      OP_OCT_TO_VAL: begin
        mul              = MUL_8;
        digs[BCD_W-1:0]  = d_bcd[MAG_W];
      end
      OP_HEX_TO_VAL: begin
        mul = MUL_16;
        for (int i = 0; i < HEX_CHARS; i++) begin
          if (LEN_W'(i) < len_eff) begin
            digs[i*DIG_W +: DIG_W] = hex_char_value(p_text[i*BYTE_W +: BYTE_W]);
          end
        end
      end
      OP_VAL_TO_BIN: begin
        mul = MUL_10;
        for (int i = 0; i < MAG_W; i++) begin
          digs[i*DIG_W +: DIG_W] = {3'b000, p_mag[i]};
        end
      end
      OP_VAL_TO_OCT: begin
        mul = MUL_10;
        for (int i = 0; i < NOCT; i++) begin
          digs[i*DIG_W +: DIG_W] = {1'b0, magx[i*3 +: 3]};
        end
      end
      OP_VAL_TO_HEX: begin
        sel_text = emit_text;
        sel_len  = emit_len;
        sel_ovf  = emit_ovf;
      end
      default: begin
      end
    endcase
  end

  // multiply-accumulate chain, most significant digit first
  logic [NDIG:0]          h_valid;
  logic [NDIG:0]          h_big;
  logic [VALUE_WIDTH-1:0] h_acc [0:NDIG];
  logic [SB2_W-1:0]       h_sb  [0:NDIG];

  assign h_valid[0] = d_valid[MAG_W];
  assign h_big[0]   = 1'b0;
  assign h_acc[0]   = '0;
  assign h_sb[0]    = {sel_text, sel_len, sel_ovf, mul, digs};

  for (genvar k = 0; k < NDIG; k++) begin : g_horner
    rcu_horner_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SB_W        (SB2_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (h_valid[k]),
      .acc_i   (h_acc[k]),
      .big_i   (h_big[k]),
      .digit_i (h_sb[k][(NDIG-1-k)*DIG_W +: DIG_W]),
      .mul_i   (mul_t'(h_sb[k][DIGS_W +: MUL_W])),
      .sb_i    (h_sb[k]),
      .valid_o (h_valid[k+1]),
      .acc_o   (h_acc[k+1]),
      .big_o   (h_big[k+1]),
      .sb_o    (h_sb[k+1])
    );
  end

  // output register and skid register
  logic [RES_W-1:0] res_word;
  logic             take;
  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [RES_W-1:0] out_data_r, out_data_nxt;
  logic [RES_W-1:0] skid_data_r, skid_data_nxt;

  assign res_word = {h_acc[NDIG],
                     h_sb[NDIG][SB2_W-1 -: TEXT_W],
                     h_sb[NDIG][SB2_W-TEXT_W-1 -: LEN_W],
                     h_big[NDIG] | h_sb[NDIG][MUL_W + DIGS_W]};

  assign en   = !skid_v_r;
  assign take = en && h_valid[NDIG];

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (out_ch.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_data_nxt = skid_data_r;
        out_v_nxt    = 1'b1;
        skid_v_nxt   = 1'b0;
      end else if (take) begin
        out_data_nxt = res_word;
        out_v_nxt    = 1'b1;
      end else begin
        out_v_nxt    = 1'b0;
      end
    end else if (take) begin
      skid_data_nxt = res_word;
      skid_v_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ch.ready           = en;
  assign out_ch.valid          = out_v_r;
  assign out_ch.result_value   = out_data_r[RES_W-1 -: VALUE_WIDTH];
  assign out_ch.hex_text_out   = out_data_r[LEN_W + 1 +: TEXT_W];
  assign out_ch.hex_length_out = out_data_r[1 +: LEN_W];
  assign out_ch.overflow       = out_data_r[0];

endmodule
`default_nettype wire
